// File: rtl/pmp_pkg.sv
// shared types, widths and command codes for the polygon mass properties block
package pmp_pkg;

   localparam int COORD_W        = 12;
   localparam int MAX_VERTS_DEF  = 256;
   localparam int COORD_BITS_DEF = 12;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DENSITY  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MASS     = 2'd3;

   // long division: 57 x 16 bit product over a divisor of up to 35 bits
   localparam int DIV_N_W   = 73;
   localparam int DIV_D_W   = 35;
   localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

   localparam int MUL_SEL_W = 4;
   localparam logic [MUL_SEL_W-1:0] MUL_NONE = 4'd0;
   localparam logic [MUL_SEL_W-1:0] MUL_AB   = 4'd1;
   localparam logic [MUL_SEL_W-1:0] MUL_BA   = 4'd2;
   localparam logic [MUL_SEL_W-1:0] MUL_CN   = 4'd3;
   localparam logic [MUL_SEL_W-1:0] MUL_DN   = 4'd4;
   localparam logic [MUL_SEL_W-1:0] MUL_NXX  = 4'd5;
   localparam logic [MUL_SEL_W-1:0] MUL_NYY  = 4'd6;
   localparam logic [MUL_SEL_W-1:0] MUL_CXX  = 4'd7;
   localparam logic [MUL_SEL_W-1:0] MUL_CYY  = 4'd8;
   localparam logic [MUL_SEL_W-1:0] MUL_W    = 4'd9;

   localparam int ACC_OP_W = 3;
   localparam logic [ACC_OP_W-1:0] ACC_NONE     = 3'd0;
   localparam logic [ACC_OP_W-1:0] ACC_AREA_ADD = 3'd1;
   localparam logic [ACC_OP_W-1:0] ACC_AREA_SUB = 3'd2;
   localparam logic [ACC_OP_W-1:0] ACC_CR_LOAD  = 3'd3;
   localparam logic [ACC_OP_W-1:0] ACC_CR_SUB   = 3'd4;
   localparam logic [ACC_OP_W-1:0] ACC_S_LOAD   = 3'd5;
   localparam logic [ACC_OP_W-1:0] ACC_S_ADD    = 3'd6;
   localparam logic [ACC_OP_W-1:0] ACC_W_ADD    = 3'd7;

   localparam int FMUL_SEL_W = 2;
   localparam logic [FMUL_SEL_W-1:0] FMUL_NONE = 2'd0;
   localparam logic [FMUL_SEL_W-1:0] FMUL_AREA = 2'd1;
   localparam logic [FMUL_SEL_W-1:0] FMUL_W_D  = 2'd2;
   localparam logic [FMUL_SEL_W-1:0] FMUL_W_M  = 2'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] vertex_x;
      logic signed [COORD_W-1:0] vertex_y;
      logic                      last_vertex;
   } req_type;

   typedef struct packed {
      logic signed [31:0] twice_area_signed;
      logic [46:0]        mass_out;
      logic [62:0]        moment_by_density;
      logic [40:0]        moment_by_mass;
      logic               zero_area_flag;
      logic               saturated_flag;
      logic               too_many_flag;
   } rsp_type;

   typedef struct packed {
      logic                  accept;
      logic                  load_close;
      logic [MUL_SEL_W-1:0]  mul_sel;
      logic [ACC_OP_W-1:0]   acc_op;
      logic [FMUL_SEL_W-1:0] fmul_sel;
      logic                  cap_mass;
      logic                  div_start;
      logic                  div_by_cross;
      logic                  cap_md;
      logic                  out_load;
   } cmd_type;

   typedef struct packed {
      logic edge_ok;
      logic in_last;
      logic div_busy;
      logic cross_zero;
   } status_type;

endpackage

// File: rtl/pmp_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module pmp_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pmp_pkg::DIV_N_W-1:0]  dividend,
   input  logic [pmp_pkg::DIV_D_W-1:0]  divisor,
   output logic                         busy,
   output logic [pmp_pkg::DIV_N_W-1:0]  quotient
);
   import pmp_pkg::*;

   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_D_W-1:0]   rem_ff;
   logic [DIV_D_W-1:0]   div_ff;
   logic [DIV_N_W-1:0]   quo_ff;
   logic [DIV_D_W:0]     trial;
   logic [DIV_D_W:0]     diff;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIV_N_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = trial >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= DIV_CNT_W'(DIV_N_W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         div_ff <= divisor;
         quo_ff <= dividend;
      end else if (cnt_ff != '0) begin
         rem_ff <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
         quo_ff <= {quo_ff[DIV_N_W-2:0], fits};
      end
   end

   assign busy     = cnt_ff != '0;
   assign quotient = quo_ff;

endmodule

// File: rtl/pmp_datapath.sv
// vertex registers, edge multiplier, accumulators and final scaling
module pmp_datapath #(
   parameter int MAX_VERTS  = pmp_pkg::MAX_VERTS_DEF,
   parameter int COORD_BITS = pmp_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pmp_pkg::req_type                req_data,
   input  logic                            csr_write,
   input  logic [pmp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pmp_pkg::CSR_DATA_W-1:0]  csr_data,
   input  pmp_pkg::cmd_type                cmd,
   output pmp_pkg::status_type             st,
   output pmp_pkg::rsp_type                rsp_data
);
   import pmp_pkg::*;

   localparam int CNT_W = $clog2(MAX_VERTS + 1);

   // coordinates use the low COORD_BITS bits, sign extended
   logic signed [COORD_BITS-1:0] vx_s, vy_s, csr_s;
   logic signed [COORD_W-1:0]    vx, vy, csr_c;

   assign vx_s  = req_data.vertex_x[COORD_BITS-1:0];
   assign vy_s  = req_data.vertex_y[COORD_BITS-1:0];
   assign csr_s = csr_data[COORD_BITS-1:0];
   assign vx    = COORD_W'(vx_s);
   assign vy    = COORD_W'(vy_s);
   assign csr_c = COORD_W'(csr_s);

   logic signed [COORD_W-1:0] center_x_ff, center_y_ff;
   logic [15:0]               density_ff, mass_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff   <= '0;
         center_y_ff   <= '0;
         density_ff    <= 16'd256;
         mass_value_ff <= 16'd256;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_CENTER_X: center_x_ff   <= csr_c;
            CSR_CENTER_Y: center_y_ff   <= csr_c;
            CSR_DENSITY:  density_ff    <= csr_data;
            CSR_MASS:     mass_value_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // polygon bookkeeping
   logic signed [COORD_W-1:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic [CNT_W-1:0]          count_ff;
   logic                      overflow_ff;
   logic                      cnt_room;

   assign cnt_room = count_ff < CNT_W'(MAX_VERTS);

   always_ff @(posedge clock) begin
      if (reset || cmd.out_load) begin
         first_x_ff  <= '0;
         first_y_ff  <= '0;
         prev_x_ff   <= '0;
         prev_y_ff   <= '0;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else if (cmd.accept) begin
         if (cnt_room) begin
            if (count_ff == '0) begin
               first_x_ff <= vx;
               first_y_ff <= vy;
            end
            prev_x_ff <= vx;
            prev_y_ff <= vy;
            count_ff  <= count_ff + 1'b1;
         end else begin
            overflow_ff <= 1'b1;
         end
      end
   end

   // edge end points a -> b
   logic signed [COORD_W-1:0] ax_ff, ay_ff, bx_ff, by_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ax_ff <= prev_x_ff;
         ay_ff <= prev_y_ff;
         bx_ff <= vx;
         by_ff <= vy;
      end else if (cmd.load_close) begin
         ax_ff <= prev_x_ff;
         ay_ff <= prev_y_ff;
         bx_ff <= first_x_ff;
         by_ff <= first_y_ff;
      end
   end

   logic signed [12:0] cx, cy, nx, ny;
   logic signed [13:0] nsx, nsy;

   assign cx  = 13'(ax_ff) - 13'(center_x_ff);
   assign cy  = 13'(ay_ff) - 13'(center_y_ff);
   assign nx  = 13'(bx_ff) - 13'(center_x_ff);
   assign ny  = 13'(by_ff) - 13'(center_y_ff);
   assign nsx = 14'(nx) + 14'(cx);
   assign nsy = 14'(ny) + 14'(cy);

   logic signed [27:0] cr_ff;
   logic signed [29:0] s_ff;
   logic [27:0]        cr_mag;
   logic [25:0]        cabs;
   logic [26:0]        su;

   assign cr_mag = cr_ff[27] ? 28'(-cr_ff) : 28'(cr_ff);
   assign cabs   = cr_mag[25:0];
   assign su     = s_ff[29] ? '0 : s_ff[26:0];

   // shared edge multiplier, product registered
   logic signed [28:0] a_op, b_op;
   logic signed [57:0] prod_in, prod_ff;

   always_comb begin
      a_op = '0;
      b_op = '0;
      unique case (cmd.mul_sel)
         MUL_AB:  begin a_op = 29'(ax_ff); b_op = 29'(by_ff); end
         MUL_BA:  begin a_op = 29'(ay_ff); b_op = 29'(bx_ff); end
         MUL_CN:  begin a_op = 29'(cx);    b_op = 29'(ny);    end
         MUL_DN:  begin a_op = 29'(cy);    b_op = 29'(nx);    end
         MUL_NXX: begin a_op = 29'(nx);    b_op = 29'(nsx);   end
         MUL_NYY: begin a_op = 29'(ny);    b_op = 29'(nsy);   end
         MUL_CXX: begin a_op = 29'(cx);    b_op = 29'(cx);    end
         MUL_CYY: begin a_op = 29'(cy);    b_op = 29'(cy);    end
         MUL_W: begin
            a_op = signed'({3'b000, cabs});
            b_op = signed'({2'b00, su});
         end
         default: ;
      endcase
   end

   assign prod_in = a_op * b_op;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      unique case (cmd.acc_op)
         ACC_CR_LOAD: cr_ff <= 28'(prod_ff);
         ACC_CR_SUB:  cr_ff <= cr_ff - 28'(prod_ff);
         ACC_S_LOAD:  s_ff  <= 30'(prod_ff);
         ACC_S_ADD:   s_ff  <= s_ff + 30'(prod_ff);
         default: ;
      endcase
   end

   logic signed [33:0] area_ff;
   logic [31:0]        cross_ff;
   logic [56:0]        wacc_ff;
   logic               wsat_ff;
   logic [57:0]        w_sum;
   logic [32:0]        c_sum;

   assign w_sum = {1'b0, wacc_ff} + 58'(prod_ff[51:0]);
   assign c_sum = {1'b0, cross_ff} + 33'(cabs);

   always_ff @(posedge clock) begin
      if (reset || cmd.out_load) begin
         area_ff  <= '0;
         cross_ff <= '0;
         wacc_ff  <= '0;
         wsat_ff  <= 1'b0;
      end else begin
         unique case (cmd.acc_op)
            ACC_AREA_ADD: area_ff <= area_ff + 34'(prod_ff);
            ACC_AREA_SUB: area_ff <= area_ff - 34'(prod_ff);
            ACC_W_ADD: begin
               // both sums clip at all ones
               cross_ff <= c_sum[32] ? '1 : c_sum[31:0];
               wacc_ff  <= w_sum[57] ? '1 : w_sum[56:0];
               if (w_sum[57]) begin
                  wsat_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // final scaling
   logic [33:0]        area_mag;
   logic [56:0]        fa;
   logic [15:0]        fb;
   logic [72:0]        fprod_ff;

   assign area_mag = area_ff[33] ? 34'(-area_ff) : 34'(area_ff);

   always_comb begin
      fa = '0;
      fb = '0;
      unique case (cmd.fmul_sel)
         FMUL_AREA: begin fa = 57'(area_mag); fb = density_ff;    end
         FMUL_W_D:  begin fa = wacc_ff;       fb = density_ff;    end
         FMUL_W_M:  begin fa = wacc_ff;       fb = mass_value_ff; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      fprod_ff <= fa * fb;
   end

   // divide by twelve: drop two bits, then a shift-add series for the third,
   // one term a cycle, and a small remainder fix-up (the series is never high
   // and falls short by at most six, so the remainder stays below 32)
   localparam int D3_W = DIV_N_W - 2;

   logic [3:0]         d3_cnt_ff;
   logic [D3_W-1:0]    d3_n_ff, d3_q_ff, d3_r_full;
   logic [4:0]         d3_r_ff;
   logic [8:0]         d3_fix;
   logic               d3_start, d3_busy;
   logic [DIV_N_W-1:0] quot12;

   assign d3_start  = cmd.div_start && !cmd.div_by_cross;
   assign d3_busy   = d3_cnt_ff != '0;
   assign d3_r_full = d3_n_ff - (d3_q_ff + {d3_q_ff[D3_W-2:0], 1'b0});
   assign d3_fix    = 9'(d3_r_ff) * 9'd11;
   assign quot12    = DIV_N_W'(d3_q_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         d3_cnt_ff <= '0;
      end else if (d3_start) begin
         d3_cnt_ff <= 4'd8;
      end else if (d3_busy) begin
         d3_cnt_ff <= d3_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (d3_start) begin
         d3_n_ff <= fprod_ff[DIV_N_W-1:2];
      end else begin
         unique case (d3_cnt_ff)
            4'd8: d3_q_ff <= (d3_n_ff >> 2) + (d3_n_ff >> 4);
            4'd7: d3_q_ff <= d3_q_ff + (d3_q_ff >> 4);
            4'd6: d3_q_ff <= d3_q_ff + (d3_q_ff >> 8);
            4'd5: d3_q_ff <= d3_q_ff + (d3_q_ff >> 16);
            4'd4: d3_q_ff <= d3_q_ff + (d3_q_ff >> 32);
            4'd3: d3_q_ff <= d3_q_ff + (d3_q_ff >> 64);
            4'd2: d3_r_ff <= d3_r_full[4:0];
            4'd1: d3_q_ff <= d3_q_ff + D3_W'(d3_fix[8:5]);
            default: ;
         endcase
      end
   end

   logic [DIV_D_W-1:0] div6;
   logic [DIV_N_W-1:0] quot;
   logic               div_busy;

   assign div6 = DIV_D_W'({cross_ff, 2'b00}) + DIV_D_W'({cross_ff, 1'b0});

   pmp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start && cmd.div_by_cross),
      .dividend (fprod_ff),
      .divisor  (div6),
      .busy     (div_busy),
      .quotient (quot)
   );

   logic [46:0] mass_res_ff;
   logic [62:0] momd_ff;
   logic        satd_ff;
   logic        md_over;

   assign md_over = quot12[72:63] != '0;

   always_ff @(posedge clock) begin
      if (cmd.cap_mass) begin
         mass_res_ff <= fprod_ff[47:1];
      end
      if (cmd.cap_md) begin
         momd_ff <= md_over ? '1 : quot12[62:0];
         satd_ff <= wsat_ff | md_over;
      end
   end

   logic signed [31:0] a32;
   logic [40:0]        momm;
   logic               mm_big;

   // a plain quotient of 2^41 or more clips even when mass is zero
   assign mm_big = (DIV_D_W'(wacc_ff[56:41]) >= div6) || (quot[72:41] != '0);

   always_comb begin
      if (area_ff[33:31] == 3'b000 || area_ff[33:31] == 3'b111) begin
         a32 = area_ff[31:0];
      end else if (area_ff[33]) begin
         a32 = 32'sh8000_0000;
      end else begin
         a32 = 32'sh7fff_ffff;
      end
      if (cross_ff == '0) begin
         momm = '0;
      end else if (mm_big) begin
         momm = '1;
      end else begin
         momm = quot[40:0];
      end
   end

   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.twice_area_signed <= a32;
         rsp_ff.mass_out          <= mass_res_ff;
         rsp_ff.moment_by_density <= momd_ff;
         rsp_ff.moment_by_mass    <= momm;
         rsp_ff.zero_area_flag    <= cross_ff == '0;
         rsp_ff.saturated_flag    <= satd_ff;
         rsp_ff.too_many_flag     <= overflow_ff;
      end
   end

   assign rsp_data      = rsp_ff;
   assign st.edge_ok    = (count_ff != '0) && cnt_room;
   assign st.in_last    = req_data.last_vertex;
   assign st.div_busy   = div_busy | d3_busy;
   assign st.cross_zero = cross_ff == '0;

endmodule

// File: rtl/pmp_ctrl.sv
// sequencer: vertex intake, edge multiply steps, final scaling and result transfer
module pmp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pmp_pkg::cmd_type     cmd,
   input  pmp_pkg::status_type  st
);
   import pmp_pkg::*;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_EDGE    = 4'd1;
   localparam logic [3:0] ST_CLOSE   = 4'd2;
   localparam logic [3:0] ST_FIN_A   = 4'd3;
   localparam logic [3:0] ST_FIN_B   = 4'd4;
   localparam logic [3:0] ST_FIN_C   = 4'd5;
   localparam logic [3:0] ST_WAIT_MD = 4'd6;
   localparam logic [3:0] ST_DIV_MM  = 4'd7;
   localparam logic [3:0] ST_WAIT_MM = 4'd8;
   localparam logic [3:0] ST_OUT     = 4'd9;

   localparam logic [3:0] EDGE_LAST = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic       close_ff, close_in;
   logic       pend_ff, pend_in;
   logic       rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      step_in  = step_ff;
      close_in = close_ff;
      pend_in  = pend_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               pend_in    = st.in_last;
               close_in   = 1'b0;
               step_in    = '0;
               if (st.edge_ok) begin
                  state_in = ST_EDGE;
               end else if (st.in_last) begin
                  state_in = ST_CLOSE;
               end
            end
         end
         ST_CLOSE: begin
            cmd.load_close = 1'b1;
            close_in       = 1'b1;
            step_in        = '0;
            state_in       = ST_EDGE;
         end
         ST_EDGE: begin
            // multiply issued in one step is accumulated in the next
            unique case (step_ff)
               4'd0: cmd.mul_sel = MUL_AB;
               4'd1: begin cmd.mul_sel = MUL_BA;  cmd.acc_op = ACC_AREA_ADD; end
               4'd2: begin cmd.mul_sel = MUL_CN;  cmd.acc_op = ACC_AREA_SUB; end
               4'd3: begin cmd.mul_sel = MUL_DN;  cmd.acc_op = ACC_CR_LOAD;  end
               4'd4: begin cmd.mul_sel = MUL_NXX; cmd.acc_op = ACC_CR_SUB;   end
               4'd5: begin cmd.mul_sel = MUL_NYY; cmd.acc_op = ACC_S_LOAD;   end
               4'd6: begin cmd.mul_sel = MUL_CXX; cmd.acc_op = ACC_S_ADD;    end
               4'd7: begin cmd.mul_sel = MUL_CYY; cmd.acc_op = ACC_S_ADD;    end
               4'd8: cmd.acc_op = ACC_S_ADD;
               4'd9: cmd.mul_sel = MUL_W;
               4'd10: cmd.acc_op = ACC_W_ADD;
               default: ;
            endcase
            if (step_ff == EDGE_LAST) begin
               if (close_ff) begin
                  state_in = ST_FIN_A;
               end else if (pend_ff) begin
                  state_in = ST_CLOSE;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_FIN_A: begin
            cmd.fmul_sel = FMUL_AREA;
            state_in     = ST_FIN_B;
         end
         ST_FIN_B: begin
            cmd.cap_mass = 1'b1;
            cmd.fmul_sel = FMUL_W_D;
            state_in     = ST_FIN_C;
         end
         ST_FIN_C: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT_MD;
         end
         ST_WAIT_MD: begin
            if (!st.div_busy) begin
               cmd.cap_md   = 1'b1;
               cmd.fmul_sel = FMUL_W_M;
               state_in     = ST_DIV_MM;
            end
         end
         ST_DIV_MM: begin
            if (st.cross_zero) begin
               state_in = ST_OUT;
            end else begin
               cmd.div_start    = 1'b1;
               cmd.div_by_cross = 1'b1;
               state_in         = ST_WAIT_MM;
            end
         end
         ST_WAIT_MM: begin
            if (!st.div_busy) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         close_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         close_ff <= close_in;
         pend_ff  <= pend_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/polygon_mass_properties.sv
// top level of the polygon area and moment of inertia block
//
// vertices come in on the req_ channel, one per transfer, signed Q8.4; the
// transfer with last_vertex set closes the polygon back to its first vertex.
// one result per polygon leaves on the rsp_ channel: twice the signed area,
// mass, the density based and mass based moments and three flags.
// csr_ writes set center, density and mass; csr_ready is always high.
// the first vertex of a polygon is only stored; every later vertex up to
// MAX_VERTS is accepted and then runs 11 steps of the shared edge multiplier.
// the last vertex adds the closing edge and final scaling: the shift-add
// divide by twelve and the 73-step bit-serial divider behind the mass based
// moment; with a zero cross sum that second divide is skipped.
// one result register sits on the output: while it waits under rsp_stall the
// next polygon's vertices are taken; only the next result then waits.
// vertices past MAX_VERTS are dropped and reported in too_many_flag.
// synchronous reset clears the polygon state, the output valid and the
// sequencer, and sets center to 0 and density and mass to 1.0.
module polygon_mass_properties #(
   parameter int MAX_VERTS  = pmp_pkg::MAX_VERTS_DEF,
   parameter int COORD_BITS = pmp_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  pmp_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output pmp_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pmp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pmp_pkg::CSR_DATA_W-1:0]  csr_data
);
   import pmp_pkg::*;

   cmd_type    cmd;
   status_type st;

   assign csr_ready = 1'b1;

   pmp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .st        (st)
   );

   pmp_datapath #(
      .MAX_VERTS  (MAX_VERTS),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .st        (st),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/pmp_checker.sv
// port level checks for the polygon mass properties block, bound to the top level
module pmp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input pmp_pkg::req_type                req_data,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input pmp_pkg::rsp_type                rsp_data
);
   import pmp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("stalled result changed");

   // a closing vertex always starts a busy phase
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.last_vertex |=> req_stall && !rsp_valid ||
      req_stall)
      else $error("intake not held after last vertex");

   a_zero_moment: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_area_flag |-> rsp_data.moment_by_mass == '0)
      else $error("mass moment not zero on zero cross sum");

endmodule

bind polygon_mass_properties pmp_checker u_pmp_checker (.*);

// File: dv/polygon_mass_properties_checker.sv
// checker: watches the vertex, result and register channels, predicts each polygon result and compares
`timescale 1ns / 100ps
module polygon_mass_properties_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  pmp_pkg::req_type                req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  pmp_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [pmp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pmp_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                              fail_count,
   output int                              results_pending
);
   import pmp_pkg::*;

   localparam int          VERT_LIMIT = MAX_VERTS_DEF;
   localparam longint unsigned CROSS_MAX = 64'hFFFF_FFFF;
   localparam longint unsigned WEIGHT_MAX = (64'd1 << 57) - 1;
   localparam longint unsigned MOMD_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam longint unsigned MOMM_MAX = (64'd1 << 41) - 1;

   longint          ctr_x, ctr_y;
   longint unsigned density, mass;
   longint          first_x, first_y, prev_x, prev_y;
   int              nverts;
   longint          area_sum;
   longint unsigned cross_sum, weight_sum;
   bit              dropped, weight_clipped;
   rsp_type         polygon_results[$];

   assign results_pending = polygon_results.size();

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic clear_polygon();
      first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
      nverts = 0; area_sum = 0; cross_sum = 0; weight_sum = 0;
      dropped = 0; weight_clipped = 0;
   endtask

   task automatic add_edge(input longint ax, input longint ay, input longint bx, input longint by);
      longint cx, cy, nx, ny, cr, s;
      longint unsigned cabs, su, prod;
      cx = ax - ctr_x; cy = ay - ctr_y;
      nx = bx - ctr_x; ny = by - ctr_y;
      cr = cx * ny - cy * nx;
      cabs = cr < 0 ? -cr : cr;
      s = nx * nx + ny * ny + nx * cx + ny * cy + cx * cx + cy * cy;
      su = s < 0 ? 0 : s;
      area_sum += ax * by - ay * bx;
      if (cross_sum > CROSS_MAX || cabs > CROSS_MAX - cross_sum) cross_sum = CROSS_MAX;
      else cross_sum += cabs;
      prod = cabs * su;
      if (weight_sum > WEIGHT_MAX || prod > WEIGHT_MAX - weight_sum) begin
         weight_sum = WEIGHT_MAX;
         weight_clipped = 1;
      end else begin
         weight_sum += prod;
      end
   endtask

   task automatic take_vertex(input req_type v);
      longint x, y, a32;
      longint unsigned abs_area, d, q;
      logic [127:0] wide;
      rsp_type r;
      x = v.vertex_x;
      y = v.vertex_y;
      if (nverts < VERT_LIMIT) begin
         if (nverts == 0) begin
            first_x = x; first_y = y;
         end else begin
            add_edge(prev_x, prev_y, x, y);
         end
         prev_x = x; prev_y = y;
         nverts++;
      end else begin
         dropped = 1;
      end
      if (!v.last_vertex) return;
      if (nverts > 0) add_edge(prev_x, prev_y, first_x, first_y);

      a32 = area_sum;
      if (a32 > 64'sd2147483647) a32 = 64'sd2147483647;
      if (a32 < -64'sd2147483648) a32 = -64'sd2147483648;
      r.twice_area_signed = a32[31:0];
      abs_area = area_sum < 0 ? -area_sum : area_sum;
      r.mass_out = 47'((abs_area * density) >> 1);

      r.saturated_flag = weight_clipped;
      wide = 128'(weight_sum) * density / 12;
      if (wide > MOMD_MAX) begin
         wide = MOMD_MAX;
         r.saturated_flag = 1;
      end
      r.moment_by_density = wide[62:0];

      if (cross_sum == 0) begin
         wide = 0;
      end else begin
         d = cross_sum * 6;
         q = weight_sum / d;
         if (q > MOMM_MAX) wide = MOMM_MAX;
         else begin
            wide = 128'(weight_sum) * mass / d;
            if (wide > MOMM_MAX) wide = MOMM_MAX;
         end
      end
      r.moment_by_mass = wide[40:0];
      r.zero_area_flag = cross_sum == 0;
      r.too_many_flag = dropped;
      polygon_results.push_back(r);
      clear_polygon();
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (polygon_results.size() == 0) begin
         report("unexpected result area", 64'(got.twice_area_signed), 0);
         return;
      end
      want = polygon_results.pop_front();
      if (got.twice_area_signed !== want.twice_area_signed)
         report("twice_area_signed", 64'(got.twice_area_signed), 64'(want.twice_area_signed));
      if (got.mass_out !== want.mass_out) report("mass_out", 64'(got.mass_out), 64'(want.mass_out));
      if (got.moment_by_density !== want.moment_by_density)
         report("moment_by_density", 64'(got.moment_by_density), 64'(want.moment_by_density));
      if (got.moment_by_mass !== want.moment_by_mass)
         report("moment_by_mass", 64'(got.moment_by_mass), 64'(want.moment_by_mass));
      if (got.zero_area_flag !== want.zero_area_flag)
         report("zero_area_flag", 64'(got.zero_area_flag), 64'(want.zero_area_flag));
      if (got.saturated_flag !== want.saturated_flag)
         report("saturated_flag", 64'(got.saturated_flag), 64'(want.saturated_flag));
      if (got.too_many_flag !== want.too_many_flag)
         report("too_many_flag", 64'(got.too_many_flag), 64'(want.too_many_flag));
   endtask

   initial begin
      fail_count = 0;
      ctr_x = 0; ctr_y = 0; density = 256; mass = 256;
      clear_polygon();
   end

   always @(posedge clock) begin
      if (reset) begin
         ctr_x = 0; ctr_y = 0; density = 256; mass = 256;
         clear_polygon();
         polygon_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CENTER_X: ctr_x = longint'($signed(csr_data[COORD_W-1:0]));
               CSR_CENTER_Y: ctr_y = longint'($signed(csr_data[COORD_W-1:0]));
               CSR_DENSITY:  density = csr_data;
               CSR_MASS:     mass = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
         if (req_valid && !req_stall) take_vertex(req_data);
      end
   end
endmodule

// File: dv/polygon_mass_properties_tb.sv
// testbench top: clock, reset, vertex and register stimulus, result stalls and verdict
`timescale 1ns / 100ps
module polygon_mass_properties_tb;
   import pmp_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE = 250;

   logic                  clock, reset;
   logic                  req_valid, req_stall;
   req_type               req_data;
   logic                  rsp_valid, rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    fail_count, results_pending;
   int                    cycles;
   bit                    bursty, hold_off;
   int                    vertices_sent;

   polygon_mass_properties u_top (.*);

   polygon_mass_properties_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("polygon_mass_properties: mismatch");
            $finish;
         end
      end
   end

   // result side stalls; a requested hold-off keeps stall high for a long stretch
   initial begin
      int n;
      rsp_stall = 1;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1;
            n = 0;
            while (n < 2500) begin
               @(posedge clock);
               n++;
            end
            hold_off = 0;
            rsp_stall <= 0;
         end else if (bursty && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_stall <= 0;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   task automatic write_regs(input logic [15:0] cx, input logic [15:0] cy,
                             input logic [15:0] dens, input logic [15:0] m);
      logic [15:0] vals [4];
      vals = '{cx, cy, dens, m};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1;
         csr_index <= CSR_IDX_W'(i);
         csr_data <= vals[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 0;
   endtask

   task automatic send_vertex(input logic [11:0] x, input logic [11:0] y, input bit last);
      req_valid <= 1;
      req_data <= '{vertex_x: x, vertex_y: y, last_vertex: last};
      do @(posedge clock); while (req_stall);
      vertices_sent++;
      if (bursty && $urandom_range(0, 7) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      do @(posedge clock); while (results_pending != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [11:0] pick_coord(input int style);
      case (style)
         0: return $urandom_range(0, 1) ? 12'h7FF : 12'h800;
         1: return 12'($signed($urandom_range(0, 64)) - 32);
         default: return 12'($urandom);
      endcase
   endfunction

   task automatic random_polygon(input int count);
      int style;
      style = $urandom_range(0, 3);
      for (int i = 0; i < count; i++)
         send_vertex(pick_coord(style), pick_coord(style), i == count - 1);
   endtask

   task automatic random_phase(input int items);
      int goal, n;
      goal = vertices_sent + items;
      while (vertices_sent < goal) begin
         n = $urandom_range(0, 9) == 0 ? $urandom_range(9, 40) : $urandom_range(1, 8);
         random_polygon(n);
      end
   endtask

   initial begin
      req_valid = 0; req_data = '0;
      csr_valid = 0; csr_index = '0; csr_data = '0;
      bursty = 0; hold_off = 0; vertices_sent = 0;
      reset = 1;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extreme triangle, square, one and two vertex polygons, collinear
      send_vertex(12'h800, 12'h800, 0);
      send_vertex(12'h7FF, 12'h800, 0);
      send_vertex(12'h7FF, 12'h7FF, 1);
      send_vertex(12'h000, 12'h000, 0);
      send_vertex(12'h010, 12'h000, 0);
      send_vertex(12'h010, 12'h010, 0);
      send_vertex(12'h000, 12'h010, 1);
      send_vertex(12'h123, 12'hABC, 1);
      send_vertex(12'h800, 12'h7FF, 0);
      send_vertex(12'h7FF, 12'h800, 1);
      send_vertex(12'h000, 12'h000, 0);
      send_vertex(12'h010, 12'h010, 0);
      send_vertex(12'h020, 12'h020, 1);
      // clockwise full-range square that drives the accumulators hard
      send_vertex(12'h800, 12'h800, 0);
      send_vertex(12'h800, 12'h7FF, 0);
      send_vertex(12'h7FF, 12'h7FF, 0);
      send_vertex(12'h7FF, 12'h800, 1);
      drain();

      write_regs(16'h07FF, 16'h0800, 16'hFFFF, 16'hFFFF);
      send_vertex(12'h800, 12'h800, 0);
      send_vertex(12'h7FF, 12'h800, 0);
      send_vertex(12'h7FF, 12'h7FF, 1);
      bursty = 1;
      random_phase(100);
      drain();

      write_regs(16'h0800, 16'h07FF, 16'h0000, 16'h0000);
      random_phase(80);
      drain();

      // more vertices than the block holds
      write_regs(16'h0000, 16'h0000, 16'h0100, 16'h0100);
      for (int i = 0; i < 262; i++)
         send_vertex(12'($urandom), 12'($urandom), i == 261);
      drain();

      write_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      hold_off = 1;
      random_phase(100);
      drain();

      write_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      random_phase(100);
      bursty = 0;
      random_phase(50);
      drain();

      if (fail_count == 0)
         $display("polygon_mass_properties: match");
      else
         $display("polygon_mass_properties: mismatch");
      $finish;
   end
endmodule

// File: polygon_mass_properties.f
rtl/pmp_pkg.sv
rtl/pmp_div.sv
rtl/pmp_datapath.sv
rtl/pmp_ctrl.sv
rtl/polygon_mass_properties.sv
rtl/pmp_checker.sv
dv/polygon_mass_properties_checker.sv
dv/polygon_mass_properties_tb.sv
